// ----- rtl/absorbent_allpass_delay_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the allpass delay block
// Clocked implication checks, gated off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ABSORBENT_ALLPASS_DELAY_TOP_MACROS_SVH
`define ABSORBENT_ALLPASS_DELAY_TOP_MACROS_SVH

// same-cycle implication
`define AAD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AAD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aad_pkg.sv -----
// ----------------------------------------------------------------------------
// aad_pkg
// Constants, register indexes and the microcode table of the allpass delay.
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int DELAY_W    = 16;
  localparam int COEF_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;
  localparam int OPA_W      = COEF_W + 1;  // signed multiplier operand A

  localparam logic [COEF_W-1:0] ALPHA_ONE = COEF_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 2'd2;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_MUL_I,
    ST_MUL_O,
    ST_LPO,
    ST_MUL_G,
    ST_EMIT
  } step_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ACCEPT,
    JMP_OUT_FREE
  } jmp_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LPI,
    MUL_LPO,
    MUL_FB
  } mul_e;

  typedef struct packed {
    jmp_e  jmp;
    step_e next;
    mul_e  mul;
    logic  take;    // input ready
    logic  ld_lpi;  // input lowpass state update
    logic  ld_lpo;  // output lowpass state update
    logic  emit;    // result to output register and output ring
  } ucode_t;

  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    w = '{jmp: JMP_ACCEPT, next: ST_MUL_I, mul: MUL_NONE, take: 1'b1,
          ld_lpi: 1'b0, ld_lpo: 1'b0, emit: 1'b0};
    case (s)
      ST_WAIT:  ;
      ST_MUL_I: w = '{jmp: JMP_NEXT, next: ST_MUL_O, mul: MUL_LPI, take: 1'b0,
                      ld_lpi: 1'b0, ld_lpo: 1'b0, emit: 1'b0};
      ST_MUL_O: w = '{jmp: JMP_NEXT, next: ST_LPO, mul: MUL_LPO, take: 1'b0,
                      ld_lpi: 1'b1, ld_lpo: 1'b0, emit: 1'b0};
      ST_LPO:   w = '{jmp: JMP_NEXT, next: ST_MUL_G, mul: MUL_NONE, take: 1'b0,
                      ld_lpi: 1'b0, ld_lpo: 1'b1, emit: 1'b0};
      ST_MUL_G: w = '{jmp: JMP_NEXT, next: ST_EMIT, mul: MUL_FB, take: 1'b0,
                      ld_lpi: 1'b0, ld_lpo: 1'b0, emit: 1'b0};
      ST_EMIT:  w = '{jmp: JMP_OUT_FREE, next: ST_WAIT, mul: MUL_NONE, take: 1'b0,
                      ld_lpi: 1'b0, ld_lpo: 1'b0, emit: 1'b1};
      default:  ;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/absorbent_allpass_delay_top.sv -----
// ----------------------------------------------------------------------------
// absorbent_allpass_delay_top
// Schroeder allpass delay with one-pole lowpass damping on both taps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / sample_in_i) takes one signed
//   sample per item; output channel (out_valid_o / out_ready_i /
//   sample_out_o) returns exactly one saturated sample per item, in order.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 delay, 1 gain Q1.16, 2 damping alpha Q1.16 up to 1.0); write only when idle.
//   An accepted item runs the microcoded steps MUL_I, MUL_O, LPO, MUL_G
//   and EMIT, three multiplies through one shared multiplier; the result
//   is registered in EMIT. A new item waits until the sequence is done.
//   Ready is high only while the sequencer sits in its wait step.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If that register is still full when the next result is
//   done, the sequencer holds in its emit step until the receiver takes it.
//   Reset: config returns to delay 0, gain 0, alpha 1.0; pointer and both
//   lowpass states clear. The rings are not swept: a fill flag marks ring
//   entries never written since reset, and those read as zero. No clearing
//   pass, so the block is ready right after reset.
// ----------------------------------------------------------------------------
`include "absorbent_allpass_delay_top_macros.svh"

module absorbent_allpass_delay_top
  import aad_pkg::*;
#(
  parameter int RING_DEPTH_LOG2 = 16,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int AW    = RING_DEPTH_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int BW    = SAMPLE_BITS + 1;   // tap difference
  localparam int PW    = OPA_W + BW;        // product
  localparam int RW    = SAMPLE_BITS + 3;   // rounded product / sum

  localparam logic [AW-1:0] RING_MASK = {AW{1'b1}};
  localparam logic signed [RW-1:0] SMAX = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

  // config registers
  logic [DELAY_W-1:0]       delay_q;
  logic signed [COEF_W-1:0] gain_q;
  logic [COEF_W-1:0]        damp_q;

  // sequencer
  step_e  step_q, step_d;
  ucode_t uc;

  // state
  logic [AW-1:0]                 wp_q;
  logic                          full_q;     // ring has wrapped once
  logic signed [SAMPLE_BITS-1:0] lpi_q, lpo_q;
  logic                          fwd_q, tap_ok_q;

  // payload
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PW-1:0]          prod_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;
  logic                          out_valid_q;

  // rings
  logic [SAMPLE_BITS-1:0] iring [DEPTH];
  logic [SAMPLE_BITS-1:0] oring [DEPTH];
  logic [SAMPLE_BITS-1:0] iring_rd_q, oring_rd_q;

  logic                          in_fire, out_free, emit;
  logic [31:0]                   dly_ext;
  logic [AW-1:0]                 d_eff, rp;
  logic                          tap_ok;
  logic [COEF_W-1:0]             alpha;
  logic signed [SAMPLE_BITS-1:0] ri, ro;
  logic signed [OPA_W-1:0]       mul_a;
  logic signed [BW-1:0]          mul_b;
  logic signed [PW-1:0]          prod_r, prod_sh;
  logic signed [RW-1:0]          rnd, y_sum;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  assign uc       = ucode_rom(step_q);
  assign in_ready_o = uc.take;
  assign in_fire  = in_valid_i & uc.take;
  assign out_free = ~out_valid_q | out_ready_i;
  assign emit     = uc.emit & out_free;

  always_comb begin
    case (uc.jmp)
      JMP_NEXT:     step_d = uc.next;
      JMP_ACCEPT:   step_d = in_valid_i ? uc.next : step_q;
      JMP_OUT_FREE: step_d = out_free ? uc.next : step_q;
      default:      step_d = ST_WAIT;
    endcase
  end

  // read address: delay capped at depth - 1
  assign dly_ext = 32'(delay_q);
  assign d_eff   = (dly_ext > 32'(RING_MASK)) ? RING_MASK : dly_ext[AW-1:0];
  assign rp      = wp_q - d_eff;
  // before the first wrap only entries below the pointer hold data
  assign tap_ok  = full_q | (rp < wp_q);

  assign alpha = (damp_q > ALPHA_ONE) ? ALPHA_ONE : damp_q;

  // zero delay on the input tap sees the sample just written
  assign ri = fwd_q ? x_q : (tap_ok_q ? $signed(iring_rd_q) : '0);
  assign ro = tap_ok_q ? $signed(oring_rd_q) : '0;

  // lp = prev + round(alpha * (x - prev) / 2^16)
  always_comb begin
    case (uc.mul)
      MUL_LPI: begin
        mul_a = $signed({1'b0, alpha});
        mul_b = BW'(ri) - BW'(lpi_q);
      end
      MUL_LPO: begin
        mul_a = $signed({1'b0, alpha});
        mul_b = BW'(ro) - BW'(lpo_q);
      end
      MUL_FB: begin
        mul_a = OPA_W'(gain_q);
        mul_b = BW'(lpo_q) - BW'(x_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up: floor((p + 2^15) / 2^16)
  assign prod_r  = prod_q + PW'(ROUND_HALF);
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign rnd     = prod_sh[RW-1:0];
  assign y_sum   = RW'(lpi_q) + rnd;

  always_comb begin
    if (y_sum > SMAX) begin
      y_sat = SMAX[SAMPLE_BITS-1:0];
    end else if (y_sum < SMIN) begin
      y_sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= '0;
      gain_q      <= '0;
      damp_q      <= ALPHA_ONE;
      step_q      <= ST_WAIT;
      wp_q        <= '0;
      full_q      <= 1'b0;
      lpi_q       <= '0;
      lpo_q       <= '0;
      fwd_q       <= 1'b0;
      tap_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELAY: delay_q <= cfg_data_i[DELAY_W-1:0];
          CFG_GAIN:  gain_q  <= $signed(cfg_data_i);
          CFG_DAMP:  damp_q  <= cfg_data_i;
          default:   ;
        endcase
      end
      step_q <= step_d;
      if (in_fire) begin
        fwd_q    <= (d_eff == '0);
        tap_ok_q <= tap_ok;
      end
      if (uc.ld_lpi) lpi_q <= SAMPLE_BITS'(RW'(lpi_q) + rnd);
      if (uc.ld_lpo) lpo_q <= SAMPLE_BITS'(RW'(lpo_q) + rnd);
      if (emit) begin
        wp_q <= wp_q + AW'(1);
        if (wp_q == RING_MASK) full_q <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) x_q <= sample_in_i;
    if (uc.mul != MUL_NONE) prod_q <= mul_a * mul_b;
    if (emit) out_data_q <= y_sat;
  end

  // input ring: write new sample, read tap (old data on same address)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      iring_rd_q  <= iring[rp];
      iring[wp_q] <= sample_in_i;
    end
  end

  // output ring: tap read on accept, result written on emit
  always_ff @(posedge clk_i) begin
    if (in_fire) oring_rd_q <= oring[rp];
    if (emit) oring[wp_q] <= y_sat;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  // checks
  `AAD_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_fire, step_q == ST_MUL_I, "accept did not start the program")
  `AAD_ASSERT_NXT(a_emit_done, clk_i, rst_ni, emit, (step_q == ST_WAIT) && out_valid_q, "emit did not finish the item")
  `AAD_ASSERT_NXT(a_wp_hold, clk_i, rst_ni, !emit, $stable(wp_q), "write pointer moved without a result")
  `AAD_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, step_q == ST_WAIT, "ready outside the wait step")

endmodule
